// ===== design/console_line_discipline_defines.svh =====
// Assertion macros for the console line discipline.
// Taken in by the top level; expects clk_i and rst_ni in scope.
`ifndef CONSOLE_LINE_DISCIPLINE_DEFINES_SVH
`define CONSOLE_LINE_DISCIPLINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define CLD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("console line discipline assertion failed");
// Checked on every edge, reset included.
`define CLD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("console line discipline assertion failed");
`else
`define CLD_ASSERT(lbl, prop)
`define CLD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== design/cld_pkg.sv =====
// Shared types and constants for the console line discipline.
// No dependencies; used by every module of the block.
`default_nettype none

package cld_pkg;

  localparam int BUF_DEPTH_DEF = 128;
  localparam int MAX_READ_DEF  = 64;
  localparam int Q_DEPTH       = 2;

  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_DEL    = 8'h7f;
  localparam logic [7:0] KEY_CR     = 8'h0d;
  localparam logic [7:0] KEY_LF     = 8'h0a;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_DUMP,
    OP_KILL,
    OP_ERASE,
    OP_STORE,
    OP_READ
  } cmd_op_e;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_char;
    logic [6:0] read_count;
    logic       nonblocking;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic [7:0] erase_count;
    logic       dump_request;
    logic       line_ready;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [6:0] read_total;
    logic       would_block;
    logic       last;
  } out_item_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] ch;
    logic [6:0] count;
    logic       nb;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/cld_front.sv =====
// Front end: classifies incoming items into line-editor commands.
// Depends on cld_pkg.
`default_nettype none

module cld_front
  import cld_pkg::*;
#(
  parameter int MAX_READ = MAX_READ_DEF
) (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output cmd_t     push_cmd_o
);

  cmd_t cmd;

  always_comb begin
    cmd    = '0;
    cmd.op = OP_NOP;
    if (in_item_i.func) begin
      cmd.op = OP_READ;
      cmd.nb = in_item_i.nonblocking;
      // clamp the request to the largest read
      cmd.count = (in_item_i.read_count > 7'(MAX_READ)) ? 7'(MAX_READ)
                                                        : in_item_i.read_count;
    end else begin
      case (in_item_i.rx_char)
        KEY_CTRL_P: cmd.op = OP_DUMP;
        KEY_CTRL_U: cmd.op = OP_KILL;
        KEY_CTRL_H: cmd.op = OP_ERASE;
        KEY_DEL:    cmd.op = OP_ERASE;
        KEY_NUL:    cmd.op = OP_NOP;
        KEY_CR: begin
          cmd.op = OP_STORE;
          cmd.ch = KEY_LF;
        end
        default: begin
          cmd.op = OP_STORE;
          cmd.ch = in_item_i.rx_char;
        end
      endcase
    end
  end

  assign push_valid_o = in_valid_i;
  assign push_cmd_o   = cmd;
  assign in_ready_o   = push_ready_i;

endmodule

`default_nettype wire

// ===== design/cld_cmd_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on cld_pkg.
`default_nettype none

module cld_cmd_queue
  import cld_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  cmd_t             entries_q [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QAW:0]     count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != (QAW+1)'(Q_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/cld_back.sv =====
// Back end: ring pointers, line store and read sequencer; drives the result register.
// Depends on cld_pkg.
`default_nettype none

module cld_back
  import cld_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int PW = $clog2(2 * BUF_DEPTH);
  localparam int AW = $clog2(BUF_DEPTH);
  localparam logic [PW-1:0] PTR_MAX = PW'(2 * BUF_DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P = PW'(BUF_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RCHK = 2'd1;
  localparam logic [1:0] ST_RDAT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
    return (p == PTR_MAX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] p);
    return (p == '0) ? PTR_MAX : p - 1'b1;
  endfunction

  // pointers run modulo twice the depth; the sum wraps correctly in PW bits
  function automatic logic [PW-1:0] ring_dist(input logic [PW-1:0] a,
                                              input logic [PW-1:0] b);
    return (a >= b) ? a - b : a + PW'(2 * BUF_DEPTH) - b;
  endfunction

  function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return s[AW-1:0];
  endfunction

  logic [1:0]    state_q, state_d;
  logic [PW-1:0] rd_q, rd_d, cm_q, cm_d, ed_q, ed_d;
  logic [PW-1:0] ed_inc, rd_inc, kill_dist;
  logic [6:0]    got_q, got_d, target_q, target_d;
  logic          nb_q, nb_d, wb_q, wb_d;
  logic          pend_valid_q, pend_valid_d;
  logic [7:0]    pend_byte_q, pend_byte_d;
  logic [6:0]    pend_total_q, pend_total_d;
  logic [7:0]    rdata_q;
  logic [7:0]    line_store_q [BUF_DEPTH];
  logic          mem_we, mem_re;
  logic          out_valid_q, out_free, emit;
  out_item_t     out_item_q, item;

  assign out_free  = !out_valid_q || out_ready_i;
  assign ed_inc    = ring_inc(ed_q);
  assign rd_inc    = ring_inc(rd_q);
  assign kill_dist = ring_dist(ed_q, cm_q);

  always_comb begin
    state_d      = state_q;
    rd_d         = rd_q;
    cm_d         = cm_q;
    ed_d         = ed_q;
    got_d        = got_q;
    target_d     = target_q;
    nb_d         = nb_q;
    wb_d         = wb_q;
    pend_valid_d = pend_valid_q;
    pend_byte_d  = pend_byte_q;
    pend_total_d = pend_total_q;
    cmd_ready_o  = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    emit         = 1'b0;
    item         = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == OP_READ) begin
            cmd_ready_o  = 1'b1;
            got_d        = '0;
            target_d     = cmd_i.count;
            nb_d         = cmd_i.nb;
            wb_d         = 1'b0;
            pend_valid_d = 1'b0;
            state_d      = ST_RCHK;
          end else if (out_free) begin
            cmd_ready_o = 1'b1;
            emit        = 1'b1;
            item.last   = 1'b1;
            case (cmd_i.op)
              OP_DUMP: item.dump_request = 1'b1;
              OP_KILL: begin
                // the uncommitted tail never holds a newline: drop all of it
                item.erase_count = (16'(kill_dist) > 16'd255) ? 8'd255 : 8'(kill_dist);
                ed_d = cm_q;
              end
              OP_ERASE: begin
                if (ed_q != cm_q) begin
                  ed_d             = ring_dec(ed_q);
                  item.erase_count = 8'd1;
                end
              end
              OP_STORE: begin
                if (ring_dist(ed_q, rd_q) < DEPTH_P) begin
                  item.echo_valid = 1'b1;
                  item.echo_byte  = cmd_i.ch;
                  mem_we          = 1'b1;
                  ed_d            = ed_inc;
                  if (cmd_i.ch == KEY_LF || cmd_i.ch == KEY_CTRL_D ||
                      ring_dist(ed_inc, rd_q) == DEPTH_P) begin
                    cm_d            = ed_inc;
                    item.line_ready = 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_RCHK: begin
        if (got_q == target_q) begin
          state_d = ST_FIN;
        end else if (nb_q && rd_q == ed_q) begin
          state_d = ST_FIN;
        end else if (!nb_q && rd_q == cm_q) begin
          wb_d    = 1'b1;
          state_d = ST_FIN;
        end else begin
          mem_re  = 1'b1;
          state_d = ST_RDAT;
        end
      end
      ST_RDAT: begin
        // hold while the previous byte cannot leave yet
        if (!(pend_valid_q && !out_free)) begin
          if (!nb_q && rdata_q == KEY_CTRL_D) begin
            // consume only when nothing came first; else push it back
            if (got_q == '0) begin
              rd_d = rd_inc;
            end
            state_d = ST_FIN;
          end else begin
            if (rd_q == cm_q) begin
              cm_d = ring_inc(cm_q);
            end
            rd_d  = rd_inc;
            got_d = got_q + 7'd1;
            if (pend_valid_q) begin
              emit             = 1'b1;
              item.result_kind = 1'b1;
              item.data_valid  = 1'b1;
              item.data_byte   = pend_byte_q;
              item.read_total  = pend_total_q;
            end
            pend_valid_d = 1'b1;
            pend_byte_d  = rdata_q;
            pend_total_d = got_q + 7'd1;
            if ((got_q + 7'd1 == target_q) || (!nb_q && rdata_q == KEY_LF)) begin
              state_d = ST_FIN;
            end else begin
              state_d = ST_RCHK;
            end
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          emit             = 1'b1;
          item.result_kind = 1'b1;
          item.would_block = wb_q;
          item.last        = 1'b1;
          if (pend_valid_q) begin
            item.data_valid = 1'b1;
            item.data_byte  = pend_byte_q;
            item.read_total = pend_total_q;
          end
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_q         <= '0;
      cm_q         <= '0;
      ed_q         <= '0;
      got_q        <= '0;
      target_q     <= '0;
      nb_q         <= 1'b0;
      wb_q         <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_q         <= rd_d;
      cm_q         <= cm_d;
      ed_q         <= ed_d;
      got_q        <= got_d;
      target_q     <= target_d;
      nb_q         <= nb_d;
      wb_q         <= wb_d;
      pend_valid_q <= pend_valid_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_byte_q  <= pend_byte_d;
    pend_total_q <= pend_total_d;
    if (emit) begin
      out_item_q <= item;
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_store_q[slot(ed_q)] <= cmd_i.ch;
    end
    if (mem_re) begin
      rdata_q <= line_store_q[slot(rd_q)];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== design/console_line_discipline.sv =====
// Console line discipline: a terminal input line editor on a ring buffer. Characters
// (func 0) are classified and queued by the front end, then executed by the back end,
// which gives one result item per character. A read request (func 1) gives one result
// item per returned byte, or one empty item; each byte passes through the registered
// read of the line store. A two-entry command queue lets new items be taken while the
// back end or the result register is stalled.
// Top level; depends on cld_pkg, cld_front, cld_cmd_queue, cld_back and the
// console_line_discipline_defines.svh assertion macros.
`default_nettype none
`include "console_line_discipline_defines.svh"

module console_line_discipline
  import cld_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF,
  parameter int MAX_READ  = MAX_READ_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic push_valid, push_ready, q_avail, q_pop;
  cmd_t push_cmd, q_cmd;

  cld_front #(
    .MAX_READ (MAX_READ)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  cld_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (q_avail),
    .pop_ready_i  (q_pop),
    .pop_cmd_o    (q_cmd)
  );

  cld_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_avail),
    .cmd_ready_o (q_pop),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `CLD_ASSERT(a_pop_only_when_queued, q_pop |-> q_avail)
  `CLD_ASSERT(a_data_is_read_item, (out_valid_o && out_item_o.data_valid) |-> (out_item_o.result_kind && out_item_o.read_total != 7'd0))
  `CLD_ASSERT(a_read_not_interleaved, (out_valid_o && out_ready_i && out_item_o.result_kind && !out_item_o.last) |=> (!out_valid_o || out_item_o.result_kind))
  `CLD_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |=> !out_valid_o)

endmodule

`default_nettype wire

// ===== sim/cld_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the console line discipline: mirrors the ring buffer and its pointers,
// predicts the result items of each input transfer and compares the output transfers.
// Depends on cld_pkg for the item types and key codes.

module cld_checker
  import cld_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int Depth    = BUF_DEPTH_DEF;
  localparam int ReadMax  = MAX_READ_DEF;
  localparam int PrintMax = 50;

  // Pointers run modulo 2*Depth; the low seven bits select the slot.
  logic [7:0] line_mem [Depth];
  logic [7:0] rd_ptr;
  logic [7:0] cm_ptr;
  logic [7:0] ed_ptr;

  out_item_t predicted_q[$];
  int        out_seen;

  task automatic report(input string what, input out_item_t got, input out_item_t want);
    // keep the log short; every mismatch still counts
    if (fail_count_o < PrintMax)
      $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
               $time, out_seen, what, got, want);
    fail_count_o++;
  endtask

  task automatic apply_keystroke(input logic [7:0] key);
    out_item_t  item;
    logic [7:0] ch;
    logic [7:0] fill;
    logic [7:0] prev;
    item      = '0;
    item.last = 1'b1;
    ch        = key;
    fill      = ed_ptr - rd_ptr;
    if (ch == KEY_CTRL_P) begin
      item.dump_request = 1'b1;
    end else if (ch == KEY_CTRL_U) begin
      // walk back to the last newline, never into committed text
      prev = ed_ptr - 8'd1;
      while (ed_ptr != cm_ptr && line_mem[prev[6:0]] != KEY_LF) begin
        ed_ptr = prev;
        prev   = ed_ptr - 8'd1;
        if (item.erase_count != 8'hff) item.erase_count = item.erase_count + 8'd1;
      end
    end else if (ch == KEY_CTRL_H || ch == KEY_DEL) begin
      if (ed_ptr != cm_ptr) begin
        ed_ptr           = ed_ptr - 8'd1;
        item.erase_count = 8'd1;
      end
    end else if (ch != KEY_NUL && int'(fill) < Depth) begin
      if (ch == KEY_CR) ch = KEY_LF;
      item.echo_valid        = 1'b1;
      item.echo_byte         = ch;
      line_mem[ed_ptr[6:0]]  = ch;
      ed_ptr                 = ed_ptr + 8'd1;
      fill                   = ed_ptr - rd_ptr;
      if (ch == KEY_LF || ch == KEY_CTRL_D || int'(fill) == Depth) begin
        cm_ptr          = ed_ptr;
        item.line_ready = 1'b1;
      end
    end
    predicted_q.push_back(item);
  endtask

  task automatic serve_read(input logic [6:0] count, input logic nb);
    out_item_t  item;
    logic [7:0] ch;
    int         limit;
    int         got;
    logic       stalled;
    limit   = (int'(count) > ReadMax) ? ReadMax : int'(count);
    got     = 0;
    stalled = 1'b0;
    while (got < limit) begin
      if (nb) begin
        if (rd_ptr == ed_ptr) break;
      end else if (rd_ptr == cm_ptr) begin
        stalled = 1'b1;
        break;
      end
      ch = line_mem[rd_ptr[6:0]];
      // a nonblocking read past the commit point drags it along
      if (rd_ptr == cm_ptr) cm_ptr = cm_ptr + 8'd1;
      rd_ptr = rd_ptr + 8'd1;
      if (!nb && ch == KEY_CTRL_D) begin
        // push end-of-file back when data came first, else consume it
        if (got > 0) rd_ptr = rd_ptr - 8'd1;
        break;
      end
      got++;
      item             = '0;
      item.result_kind = 1'b1;
      item.data_valid  = 1'b1;
      item.data_byte   = ch;
      item.read_total  = 7'(got);
      predicted_q.push_back(item);
      if (!nb && ch == KEY_LF) break;
    end
    if (got == 0) begin
      item             = '0;
      item.result_kind = 1'b1;
    end else begin
      item = predicted_q.pop_back();
    end
    item.would_block = stalled;
    item.last        = 1'b1;
    predicted_q.push_back(item);
  endtask

  task automatic compare_item(input out_item_t got, input out_item_t want);
    if (got.result_kind != want.result_kind)
      report("result_kind", got, want);
    if (got.echo_valid != want.echo_valid)
      report("echo_valid", got, want);
    if (got.echo_byte != want.echo_byte)
      report("echo_byte", got, want);
    if (got.erase_count != want.erase_count)
      report("erase_count", got, want);
    if (got.dump_request != want.dump_request)
      report("dump_request", got, want);
    if (got.line_ready != want.line_ready)
      report("line_ready", got, want);
    if (got.data_valid != want.data_valid)
      report("data_valid", got, want);
    if (got.data_byte != want.data_byte)
      report("data_byte", got, want);
    if (got.read_total != want.read_total)
      report("read_total", got, want);
    if (got.would_block != want.would_block)
      report("would_block", got, want);
    if (got.last != want.last)
      report("last", got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr = '0;
      cm_ptr = '0;
      ed_ptr = '0;
      out_seen = 0;
      predicted_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.func) serve_read(in_item_i.read_count, in_item_i.nonblocking);
        else apply_keystroke(in_item_i.rx_char);
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_q.size() == 0) report("arrived with none expected", out_item_i, '0);
        else compare_item(out_item_i, predicted_q.pop_front());
        out_seen++;
      end
    end
    pending_o = predicted_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the console line discipline: drives keystrokes and read requests
// with random gaps and output stalls and gives the verdict. Depends on cld_pkg and
// cld_checker, which predicts and compares the result items.

module tb;
  import cld_pkg::*;

  localparam int IdleLimit   = 3000;
  localparam int RandomItems = 24;
  localparam int TailCycles  = 200;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int   fail_count;
  int   pend_count;
  int   idle_cycles = 0;
  int   ready_hold  = 0;
  int   sent        = 0;
  logic calm        = 1'b0;

  console_line_discipline i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  cld_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .pending_o   (pend_count)
  );

  always #5 clk = ~clk;

  // Mostly short pauses, now and then a long one.
  function automatic int stall_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic int idle_gap();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return stall_cycles();
  endfunction

  always @(posedge clk) begin
    if (calm) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!out_ready) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= stall_cycles() - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Returns just after the edge that takes the transfer.
  task automatic send(input in_item_t item);
    int   gap;
    logic hit;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    forever begin
      // ready is stable at the falling edge
      @(negedge clk);
      hit = in_ready;
      @(posedge clk);
      if (hit) break;
    end
    sent++;
  endtask

  task automatic key(input logic [7:0] ch);
    in_item_t item;
    item             = in_item_t'(17'($urandom));
    item.func        = 1'b0;
    item.rx_char     = ch;
    send(item);
  endtask

  task automatic ask(input logic [6:0] count, input logic nb);
    in_item_t item;
    item             = in_item_t'(17'($urandom));
    item.func        = 1'b1;
    item.read_count  = count;
    item.nonblocking = nb;
    send(item);
  endtask

  // Drop valid and hold until every predicted result has come out.
  task automatic wait_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pend_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [7:0] line_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 8'($urandom_range(8'h20, 8'h7e));
    if (pick < 78) return ($urandom_range(0, 1) == 0) ? KEY_CTRL_H : KEY_DEL;
    if (pick < 81) return KEY_CTRL_U;
    if (pick < 84) return KEY_CTRL_P;
    if (pick < 92) return 8'($urandom_range(8'h80, 8'hff));
    return 8'($urandom);
  endfunction

  function automatic logic [6:0] read_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return 7'($urandom_range(1, 16));
    if (pick < 95) return 7'($urandom_range(17, 64));
    return 7'($urandom_range(65, 127));
  endfunction

  task automatic random_line();
    int n_keys;
    n_keys = $urandom_range(0, 12);
    repeat (n_keys) key(line_char());
    case ($urandom_range(0, 10))
      0, 1, 2, 3, 4: key(KEY_CR);
      5, 6, 7:       key(KEY_LF);
      8, 9:          key(KEY_CTRL_D);
      default:       ; // leave the line open for a nonblocking read
    endcase
    repeat ($urandom_range(0, 2)) ask(read_size(), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int stop_at;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty buffer: ignored NUL, dump, erase and kill with nothing typed, empty reads.
    key(KEY_NUL);
    key(KEY_CTRL_P);
    key(KEY_CTRL_H);
    key(KEY_DEL);
    key(KEY_CTRL_U);
    ask(7'd5, 1'b0);
    ask(7'd5, 1'b1);
    ask(7'd0, 1'b0);
    // Line editing, CR translation, end-of-file commit.
    key("a"); key("b"); key(KEY_CR);
    key("x"); key(KEY_DEL); key("y"); key(KEY_CTRL_H);
    key("q"); key("r"); key(KEY_CTRL_U);
    key("h"); key(KEY_CTRL_D);
    // Stop at newline, push end-of-file back, then consume it.
    ask(7'd127, 1'b0);
    ask(7'd64, 1'b0);
    ask(7'd1, 1'b0);
    // Nonblocking reads past the commit point, end-of-file returned as data.
    key(8'hff); key(8'h80);
    ask(7'd64, 1'b1);
    key(KEY_CTRL_D);
    ask(7'd3, 1'b1);
    wait_results();

    // Fill the buffer until it commits itself, then overflow and drain.
    repeat (128) key(8'($urandom_range(8'h20, 8'h7e)));
    key("A");
    key(KEY_CR);
    key(KEY_DEL);
    ask(7'd127, 1'b0);
    ask(7'd64, 1'b0);
    ask(7'd10, 1'b0);
    // Kill an open line.
    repeat ($urandom_range(4, 12)) key(8'($urandom_range(8'h20, 8'h7e)));
    key(KEY_CTRL_U);
    key("z");
    key(KEY_CR);
    ask(7'd64, 1'b1);
    wait_results();

    stop_at = sent + RandomItems;
    while (sent < stop_at) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send(in_item_t'(17'($urandom)));
      end else begin
        random_line();
      end
      if ($urandom_range(0, 15) == 0) wait_results();
    end
    calm = 1'b0;
    // Drain anything left typed or committed.
    ask(7'd127, 1'b1);
    ask(7'd127, 1'b1);

    wait_results();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && pend_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
